@@ src/first_match_rule_packet_classifier_defines.svh @@
// ----------------------------------------------------------------------------
// First-match rule classifier: assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_MATCH_RULE_PACKET_CLASSIFIER_DEFINES_SVH
`define FIRST_MATCH_RULE_PACKET_CLASSIFIER_DEFINES_SVH

// same-cycle implication under reset
`define FMRPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmrpc check failed");

// next-cycle implication under reset
`define FMRPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmrpc check failed");

`endif

@@ src/fmrpc_pkg.sv @@
// ----------------------------------------------------------------------------
// First-match rule classifier package
// Item types, protocol and port codes, register indexes.
// ----------------------------------------------------------------------------
package fmrpc_pkg;

    localparam logic       KIND_RULE      = 1'b0;
    localparam logic       KIND_PACKET    = 1'b1;
    localparam logic [7:0] PROTO_ANY      = 8'd143;
    localparam logic [7:0] PROTO_ICMP     = 8'd1;
    localparam logic [7:0] PROTO_TCP      = 8'd6;
    localparam logic [15:0] PORT_WILDCARD = 16'd0;
    localparam logic [15:0] PORT_HIGH     = 16'd1023;
    localparam logic [5:0] ADDR_BITS      = 6'd32;
    localparam logic [1:0] REASON_MATCH   = 2'd0;
    localparam logic [1:0] REASON_NOMATCH = 2'd1;
    localparam logic [1:0] REASON_OFF     = 2'd2;
    localparam logic       CFG_TABLE_ACTIVE = 1'b0;
    localparam logic       CFG_RULE_COUNT   = 1'b1;
    localparam int         CFG_DATA_W     = 7;

    typedef struct packed {
        logic        kind;
        logic [5:0]  rule_slot;
        logic [1:0]  direction_bits;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [5:0]  source_prefix_len;
        logic [5:0]  dest_prefix_len;
        logic [7:0]  protocol_code;
        logic [15:0] source_port_num;
        logic [15:0] dest_port_num;
        logic [1:0]  ack_bits;
        logic        rule_verdict;
    } in_t;

    typedef struct packed {
        logic       verdict;
        logic [1:0] reason;
        logic [5:0] hit_index;
    } out_t;

    typedef struct packed {
        logic [1:0]  dir;
        logic [31:0] src_addr;
        logic [31:0] src_mask;
        logic [31:0] dst_addr;
        logic [31:0] dst_mask;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [1:0]  ack;
        logic        act;
    } rule_t;

    function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
        logic [5:0] p;
        p = (plen > ADDR_BITS) ? ADDR_BITS : plen;
        return ~(32'hFFFF_FFFF >> p);
    endfunction

    function automatic logic port_ok(input logic [15:0] pkt, input logic [15:0] rule);
        return (rule == PORT_WILDCARD) || ((rule == PORT_HIGH) && (pkt > PORT_HIGH))
            || (rule == pkt);
    endfunction

endpackage

@@ src/fmrpc_match.sv @@
// ----------------------------------------------------------------------------
// Rule bank and parallel compare
// Holds the rule table and registers one hit bit and action bit per rule.
// ----------------------------------------------------------------------------
module fmrpc_match
    import fmrpc_pkg::*;
#(
    parameter int NR = 64,
    parameter int CW = 9
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  in_t           wr_item,
    input  logic          pkt_valid,
    input  in_t           pkt,
    input  logic [CW-1:0] count,
    output logic [NR-1:0] hit_vec_reg,
    output logic [NR-1:0] act_vec_reg,
    output logic          valid_reg
);

    localparam int IW = (NR > 1) ? $clog2(NR) : 1;

    rule_t             rules_reg [NR];
    rule_t             rule_next;
    logic [IW+5:0]     slot_ext;
    logic [NR-1:0]     hit_next;
    logic [NR-1:0]     act_next;

    assign slot_ext = (IW+6)'(wr_item.rule_slot);

    always_comb
    begin
        rule_next.dir      = wr_item.direction_bits;
        rule_next.src_addr = wr_item.source_address;
        rule_next.src_mask = prefix_mask(wr_item.source_prefix_len);
        rule_next.dst_addr = wr_item.dest_address;
        rule_next.dst_mask = prefix_mask(wr_item.dest_prefix_len);
        rule_next.proto    = wr_item.protocol_code;
        rule_next.sport    = wr_item.source_port_num;
        rule_next.dport    = wr_item.dest_port_num;
        rule_next.ack      = wr_item.ack_bits;
        rule_next.act      = wr_item.rule_verdict;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (32'(wr_item.rule_slot) < 32'(NR)))
        begin
            rules_reg[slot_ext[IW-1:0]] <= rule_next;
        end
    end

    for (genvar i = 0; i < NR; i++)
    begin : g_rule
        logic ok;
        always_comb
        begin
            ok = (CW'(i) < count)
                && ((pkt.direction_bits & rules_reg[i].dir) != 2'b00)
                && (((pkt.source_address ^ rules_reg[i].src_addr) & rules_reg[i].src_mask) == 32'd0)
                && (((pkt.dest_address ^ rules_reg[i].dst_addr) & rules_reg[i].dst_mask) == 32'd0)
                && ((rules_reg[i].proto == PROTO_ANY) || (rules_reg[i].proto == pkt.protocol_code));
            if (pkt.protocol_code != PROTO_ICMP)
            begin
                ok = ok && port_ok(pkt.source_port_num, rules_reg[i].sport)
                    && port_ok(pkt.dest_port_num, rules_reg[i].dport);
                if (pkt.protocol_code == PROTO_TCP)
                begin
                    ok = ok && ((pkt.ack_bits & rules_reg[i].ack) != 2'b00);
                end
            end
            hit_next[i] = ok;
            act_next[i] = rules_reg[i].act;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= pkt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_vec_reg <= hit_next;
        act_vec_reg <= act_next;
    end

endmodule

@@ src/first_match_rule_packet_classifier.sv @@
// ----------------------------------------------------------------------------
// First-match rule packet classifier
// Rule table with first-match lookup of packet headers.
// ----------------------------------------------------------------------------
// Usage: pulse start with an item; busy stays low, so one item is taken
// every cycle. A rule item (kind 0) writes its slot and gives no result.
// A packet item (kind 1) gives one result on result, marked by done for a
// single cycle, once through the pipeline registers. Throughput is one
// item per cycle: every rule is compared in parallel in one stage, then the
// first hit is picked by an 8-wide group stage and a group combine stage.
// A rule write may follow a packet in the next cycle; packets see every
// rule written before them. table_active and rule_count are written through
// cfg_we, cfg_index and cfg_data; the user must do so only while no packet
// is in flight, which the block does not enforce. Reset clears the config
// registers and the pipeline valid bits; rule contents are undefined until
// written. The receiver cannot stall; it takes each result in its done cycle.
// ----------------------------------------------------------------------------
module first_match_rule_packet_classifier
    import fmrpc_pkg::*;
#(
    parameter int MAX_RULES = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  in_t                   item,
    output logic                  done,
    output out_t                  result,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NR = MAX_RULES;
    localparam int CW = 9;
    localparam int NG = (NR + 7) / 8;

    logic          active_reg;
    logic [6:0]    count_reg;
    logic [CW-1:0] count_eff;
    logic          accept;

    logic          s1_valid_reg;
    logic          s1_off_reg;
    in_t           s1_pkt_reg;

    logic [NR-1:0] hit_vec;
    logic [NR-1:0] act_vec;
    logic          s2_valid;
    logic          s2_off_reg;

    logic          s3_valid_reg;
    logic          s3_off_reg;
    logic [NG-1:0] grp_found_reg;
    logic [NG-1:0] grp_act_reg;
    logic [2:0]    grp_idx_reg [NG];
    logic [NG-1:0] grp_found_next;
    logic [NG-1:0] grp_act_next;
    logic [2:0]    grp_idx_next [NG];

    logic          done_reg;
    out_t          result_reg;
    out_t          result_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    assign count_eff = (32'(count_reg) > 32'(NR)) ? CW'(NR) : CW'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            count_reg  <= 7'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TABLE_ACTIVE: active_reg <= cfg_data[0];
                CFG_RULE_COUNT:   count_reg  <= cfg_data[6:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && (item.kind == KIND_PACKET);
            s3_valid_reg <= s2_valid;
            done_reg     <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pkt_reg <= item;
        s1_off_reg <= !active_reg;
        s2_off_reg <= s1_off_reg;
        s3_off_reg <= s2_off_reg;
    end

    fmrpc_match #(
        .NR (NR),
        .CW (CW)
    ) u_match (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (accept && (item.kind == KIND_RULE)),
        .wr_item     (item),
        .pkt_valid   (s1_valid_reg),
        .pkt         (s1_pkt_reg),
        .count       (count_eff),
        .hit_vec_reg (hit_vec),
        .act_vec_reg (act_vec),
        .valid_reg   (s2_valid)
    );

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_found_next[g] = 1'b0;
            grp_act_next[g]   = 1'b0;
            grp_idx_next[g]   = 3'd0;
            for (int j = 7; j >= 0; j--)
            begin
                if ((g * 8 + j < NR) && hit_vec[(g * 8 + j) % NR])
                begin
                    grp_found_next[g] = 1'b1;
                    grp_act_next[g]   = act_vec[(g * 8 + j) % NR];
                    grp_idx_next[g]   = 3'(j);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_found_reg <= grp_found_next;
        grp_act_reg   <= grp_act_next;
        grp_idx_reg   <= grp_idx_next;
    end

    always_comb
    begin
        result_next.verdict   = 1'b0;
        result_next.reason    = REASON_NOMATCH;
        result_next.hit_index = 6'd0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_found_reg[g])
            begin
                result_next.verdict   = grp_act_reg[g];
                result_next.reason    = REASON_MATCH;
                result_next.hit_index = 6'({6'(g), grp_idx_reg[g]});
            end
        end
        if (s3_off_reg)
        begin
            result_next.verdict   = 1'b1;
            result_next.reason    = REASON_OFF;
            result_next.hit_index = 6'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

@@ src/fmrpc_checker.sv @@
// ----------------------------------------------------------------------------
// First-match rule classifier port checker
// Watches the top-level ports and attaches by bind.
// ----------------------------------------------------------------------------
`include "first_match_rule_packet_classifier_defines.svh"

module fmrpc_checker
    import fmrpc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input in_t                   item,
    input logic                  done,
    input out_t                  result
);

    `FMRPC_ASSERT_NOW(a_done_from_packet, clk, rst_n, done, $past(start && item.kind == KIND_PACKET, 4))
    `FMRPC_ASSERT_NEXT(a_packet_gives_done, clk, rst_n, start && !busy && item.kind == KIND_PACKET, ##3 done)
    `FMRPC_ASSERT_NOW(a_off_accepts, clk, rst_n, done && result.reason == REASON_OFF, result.verdict && result.hit_index == 6'd0)
    `FMRPC_ASSERT_NOW(a_nomatch_drops, clk, rst_n, done && result.reason == REASON_NOMATCH, !result.verdict && result.hit_index == 6'd0)

endmodule

bind first_match_rule_packet_classifier fmrpc_checker u_fmrpc_checker (.*);

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// First-match rule packet classifier testbench
// Loads rule tables, classifies directed and random packet headers, and
// compares each result with a first-match prediction of the rule table.
// ----------------------------------------------------------------------------
module testbench;
    import fmrpc_pkg::*;

    localparam int SLOTS     = 64;
    localparam int LATENCY   = 4;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic [1:0]  dir_mask;
        logic [31:0] src_addr;
        logic [5:0]  src_len;
        logic [31:0] dst_addr;
        logic [5:0]  dst_len;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [1:0]  ack_mask;
        logic        action;
    } acl_entry_t;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e kind;
        in_t       hdr;
        out_t      want;
        logic      cfg_sel;
        logic [6:0] cfg_val;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    in_t                   item = '0;
    logic                  done;
    out_t                  result;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    acl_entry_t acl [SLOTS];
    logic       acl_on = 1'b0;
    logic [6:0] acl_count = 7'd0;
    out_t       verdict_q [$];
    int         cycle_cnt = 0;
    int         mismatches = 0;
    int         results_seen = 0;
    int         packets_sent = 0;
    int         rules_sent = 0;
    int         idle_pct = 0;

    first_match_rule_packet_classifier dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    function automatic logic prefix_hit(logic [31:0] a, logic [31:0] b, logic [5:0] len);
        int p;
        p = (len > 6'd32) ? 32 : int'(len);
        if (p == 0)
            return 1'b1;
        return ((a ^ b) >> (32 - p)) == 32'd0;
    endfunction

    function automatic logic port_hit(logic [15:0] pkt, logic [15:0] rule);
        return (rule == PORT_WILDCARD) || (rule == PORT_HIGH && pkt > 16'd1023)
            || (rule == pkt);
    endfunction

    function automatic logic entry_hits(acl_entry_t e, in_t p);
        if ((p.direction_bits & e.dir_mask) == 2'b00)
            return 1'b0;
        if (!prefix_hit(p.source_address, e.src_addr, e.src_len))
            return 1'b0;
        if (!prefix_hit(p.dest_address, e.dst_addr, e.dst_len))
            return 1'b0;
        if (e.proto != PROTO_ANY && e.proto != p.protocol_code)
            return 1'b0;
        if (p.protocol_code == PROTO_ICMP)
            return 1'b1;
        if (!port_hit(p.source_port_num, e.sport) || !port_hit(p.dest_port_num, e.dport))
            return 1'b0;
        if (p.protocol_code == PROTO_TCP)
            return (p.ack_bits & e.ack_mask) != 2'b00;
        return 1'b1;
    endfunction

    function automatic out_t classify_packet(in_t p);
        out_t o;
        int n;
        o = '{verdict: 1'b0, reason: REASON_NOMATCH, hit_index: 6'd0};
        if (!acl_on)
            return '{verdict: 1'b1, reason: REASON_OFF, hit_index: 6'd0};
        n = (acl_count > 7'd64) ? SLOTS : int'(acl_count);
        for (int i = 0; i < n; i++)
            if (entry_hits(acl[i], p))
                return '{verdict: acl[i].action, reason: REASON_MATCH, hit_index: i[5:0]};
        return o;
    endfunction

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("TEST FAILED");
            $finish;
        end
        if (cfg_we) begin
            if (cfg_index == CFG_TABLE_ACTIVE)
                acl_on <= cfg_data[0];
            else
                acl_count <= cfg_data;
        end
        if (done) begin
            out_t w;
            results_seen <= results_seen + 1;
            if (verdict_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end else begin
                w = verdict_q.pop_front();
                if (result.verdict !== w.verdict || result.reason !== w.reason
                    || result.hit_index !== w.hit_index) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", w, result);
                end
            end
        end
        if (rst_n && start && !busy) begin
            if (item.kind == KIND_RULE) begin
                acl[item.rule_slot] <= '{item.direction_bits, item.source_address,
                    item.source_prefix_len, item.dest_address, item.dest_prefix_len,
                    item.protocol_code, item.source_port_num, item.dest_port_num,
                    item.ack_bits, item.rule_verdict};
            end else begin
                verdict_q.push_back(classify_packet(item));
            end
        end
    end

    // hold the item until a transfer happens
    task automatic send(in_t x);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= x;
        do @(posedge clk); while (busy);
        if (x.kind == KIND_RULE)
            rules_sent++;
        else
            packets_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_cfg(logic sel, logic [6:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_proto();
        case ($urandom_range(0, 4))
            0: return PROTO_ANY;
            1: return PROTO_ICMP;
            2: return PROTO_TCP;
            3: return 8'd17;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_rule_port();
        case ($urandom_range(0, 3))
            0: return PORT_WILDCARD;
            1: return PORT_HIGH;
            2: return 16'($urandom_range(1, 2000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_t random_rule(int slot);
        in_t r;
        r = in_t'({$urandom, $urandom, $urandom, $urandom});
        r.kind = KIND_RULE;
        r.rule_slot = slot[5:0];
        r.direction_bits = ($urandom_range(0, 9) == 0) ? 2'b00 : 2'($urandom_range(1, 3));
        r.source_prefix_len = ($urandom_range(0, 7) == 0) ? 6'($urandom)
                                                          : 6'($urandom_range(0, 32));
        r.dest_prefix_len = ($urandom_range(0, 7) == 0) ? 6'($urandom)
                                                        : 6'($urandom_range(0, 32));
        r.protocol_code = pick_proto();
        r.source_port_num = pick_rule_port();
        r.dest_port_num = pick_rule_port();
        return r;
    endfunction

    function automatic logic [15:0] pkt_port(logic [15:0] rp);
        if ($urandom_range(0, 7) == 0 || rp == PORT_WILDCARD)
            return 16'($urandom);
        if (rp == PORT_HIGH)
            return 16'($urandom_range(1022, 65535));
        return rp;
    endfunction

    // aim a header at one rule and perturb it, or leave it fully random
    function automatic in_t random_packet();
        in_t p;
        acl_entry_t e;
        p = in_t'({$urandom, $urandom, $urandom, $urandom});
        p.kind = KIND_PACKET;
        if ($urandom_range(0, 3) == 0)
            return p;
        e = acl[$urandom_range(0, SLOTS - 1)];
        if (acl_count > 0 && acl_count <= 7'd64)
            e = acl[$urandom_range(0, int'(acl_count) - 1)];
        p.direction_bits = ($urandom_range(0, 9) == 0) ? 2'($urandom)
                                                       : 2'b01 << $urandom_range(0, 1);
        p.source_address = e.src_addr ^ ($urandom >> $urandom_range(1, 32));
        p.dest_address = e.dst_addr ^ ($urandom >> $urandom_range(1, 32));
        if (e.proto == PROTO_ANY || $urandom_range(0, 7) == 0)
            p.protocol_code = pick_proto();
        else
            p.protocol_code = e.proto;
        p.source_port_num = pkt_port(e.sport);
        p.dest_port_num = pkt_port(e.dport);
        p.ack_bits = ($urandom_range(0, 9) == 0) ? 2'($urandom)
                                                 : 2'b01 << $urandom_range(0, 1);
        return p;
    endfunction

    function automatic in_t rule_row(int slot, logic [1:0] dm, logic [31:0] sa, logic [5:0] sl,
            logic [31:0] da, logic [5:0] dl, logic [7:0] pr, logic [15:0] sp,
            logic [15:0] dp, logic [1:0] am, logic act);
        return '{KIND_RULE, slot[5:0], dm, sa, da, sl, dl, pr, sp, dp, am, act};
    endfunction

    function automatic in_t pkt_row(logic [1:0] d, logic [31:0] sa, logic [31:0] da,
            logic [7:0] pr, logic [15:0] sp, logic [15:0] dp, logic [1:0] ak);
        return '{KIND_PACKET, 6'h3F, d, sa, da, 6'h3F, 6'h3F, pr, sp, dp, ak, 1'b1};
    endfunction

    row_t rows [$];

    task automatic add_item(in_t x);
        rows.push_back('{ROW_ITEM, x, '0, 1'b0, 7'd0});
    endtask

    task automatic add_known(in_t x, out_t w);
        rows.push_back('{ROW_CHECKED, x, w, 1'b0, 7'd0});
    endtask

    task automatic add_cfg(logic sel, logic [6:0] val);
        rows.push_back('{ROW_CFG, '0, '0, sel, val});
    endtask

    initial begin
        int n_phase;
        logic [6:0] counts [6];
        logic       actives [6];
        int         idles [6];
        counts = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd17, 7'd64};
        actives = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
        idles = '{0, 79, 0, 20, 79, 0};

        add_known(pkt_row(2'b01, 32'h0, 32'h0, PROTO_TCP, 16'd0, 16'd0, 2'b10),
                  '{1'b1, REASON_OFF, 6'd0});
        add_item(rule_row(0, 2'b01, 32'h0A00_0000, 6'd8, 32'h0, 6'd0, PROTO_TCP,
                          PORT_WILDCARD, 16'd80, 2'b10, 1'b1));
        add_item(rule_row(1, 2'b11, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 6'd63, PROTO_ANY,
                          PORT_HIGH, PORT_WILDCARD, 2'b11, 1'b0));
        add_item(rule_row(2, 2'b11, 32'h1234_5678, 6'd0, 32'h0, 6'd0, PROTO_ICMP,
                          16'd5, 16'd5, 2'b00, 1'b1));
        add_item(rule_row(3, 2'b11, 32'h0, 6'd0, 32'h0, 6'd0, PROTO_ANY,
                          PORT_WILDCARD, PORT_WILDCARD, 2'b11, 1'b1));
        add_item(rule_row(63, 2'b11, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF, 6'h3F, 8'hFF,
                          16'hFFFF, 16'hFFFF, 2'b11, 1'b1));
        add_cfg(CFG_TABLE_ACTIVE, 7'd1);
        add_known(pkt_row(2'b01, 32'h0A01_0203, 32'h0, PROTO_TCP, 16'd1, 16'd80, 2'b10),
                  '{1'b0, REASON_NOMATCH, 6'd0});
        add_cfg(CFG_RULE_COUNT, 7'd4);
        add_item(pkt_row(2'b01, 32'h0A01_0203, 32'h0, PROTO_TCP, 16'd1, 16'd80, 2'b10));
        add_item(pkt_row(2'b01, 32'h0A01_0203, 32'h0, PROTO_TCP, 16'd1, 16'd80, 2'b01));
        add_item(pkt_row(2'b10, 32'h0A01_0203, 32'h0, PROTO_TCP, 16'd1, 16'd80, 2'b10));
        add_known(pkt_row(2'b00, 32'h0, 32'h0, 8'd17, 16'd0, 16'd0, 2'b01),
                  '{1'b0, REASON_NOMATCH, 6'd0});
        add_known(pkt_row(2'b01, 32'h0, 32'h0, PROTO_TCP, 16'd9, 16'd9, 2'b00),
                  '{1'b0, REASON_NOMATCH, 6'd0});
        add_item(pkt_row(2'b10, 32'h0, 32'h0, PROTO_ICMP, 16'd7, 16'd7, 2'b00));
        add_item(pkt_row(2'b10, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd17, 16'd2000, 16'd3, 2'b00));
        add_item(pkt_row(2'b01, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd17, 16'd1023, 16'd3, 2'b00));
        add_item(pkt_row(2'b01, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 8'd17, 16'd2000, 16'd3, 2'b00));
        add_item(pkt_row(2'b10, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'd1000, 16'hFFFF, 2'b11));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                write_cfg(rows[i].cfg_sel, rows[i].cfg_val);
            end else begin
                if (rows[i].kind == ROW_CHECKED
                    && classify_packet(rows[i].hdr) != rows[i].want) begin
                    mismatches++;
                    $display("directed row %0d: prediction disagrees with table", i);
                end
                send(rows[i].hdr);
            end
        end

        // fill every slot before any count above the directed rules
        for (int s = 0; s < SLOTS; s++)
            send(random_rule(s));

        for (int ph = 0; ph < 6; ph++) begin
            idle_pct = idles[ph];
            write_cfg(CFG_TABLE_ACTIVE, {6'd0, actives[ph]});
            write_cfg(CFG_RULE_COUNT, counts[ph]);
            n_phase = 200;
            for (int k = 0; k < n_phase; k++) begin
                if ($urandom_range(0, 4) == 0)
                    send(random_rule($urandom_range(0, SLOTS - 1)));
                else
                    send(random_packet());
            end
        end

        drain();
        $display("covered %0d packets and %0d rule writes, %0d results checked",
                 packets_sent, rules_sent, results_seen);
        $display("rule counts 0 to 127, table on and off, idle rates 0/20/79 percent");
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
